[rtl/spjq_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package spjq_pkg;

    // Fixed field widths of the item interface.
    localparam int ID_W  = 16;
    localparam int LVL_W = 3;

    typedef enum logic [1:0] {
        KIND_SUBMIT = 2'd0,
        KIND_TAKE   = 2'd1,
        KIND_CANCEL = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        STS_OK        = 3'd0,
        STS_BAD_PRIO  = 3'd1,
        STS_FULL      = 3'd2,
        STS_EMPTY     = 3'd3,
        STS_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE = 2'd0,
        S_SCAN = 2'd1,
        S_DROP = 2'd2
    } t_state;

    // Result item; the last member sits in the lowest bits.
    typedef struct packed {
        logic [1:0]      wake_worker;
        logic            wake_valid;
        logic [1:0]      job_op;
        logic [ID_W-1:0] job_id;
        t_status         status;
    } t_result;

    typedef struct packed {
        logic             append;
        logic             drop;
        logic [LVL_W-1:0] level;
        logic [1:0]       op;
    } t_chain_ctl;

    typedef struct packed {
        logic clear;
        logic step;
        logic by_level;
    } t_scan_ctl;

endpackage

`default_nettype wire

[rtl/spjq_slot_chain.sv]
`timescale 1ns / 1ps
`default_nettype none

// Arrival-ordered slot chain: append at the tail, remove by shifting down.
module spjq_slot_chain
    import spjq_pkg::*;
#(
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16,
    localparam int IW     = $clog2(SLOTS),
    localparam int CW     = $clog2(SLOTS + 1)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_chain_ctl         i_ctl,
    input  wire logic [ID_BITS-1:0] i_id,
    input  wire logic [IW-1:0]      i_pos,
    input  wire logic [IW-1:0]      i_rd_idx,
    output logic [LVL_W-1:0]        o_rd_level,
    output logic [ID_BITS-1:0]      o_rd_id,
    output logic [1:0]              o_rd_op,
    output logic [CW-1:0]           o_count
);

    logic [LVL_W-1:0]   r_level [SLOTS];
    logic [ID_BITS-1:0] r_id    [SLOTS];
    logic [1:0]         r_op    [SLOTS];
    logic [CW-1:0]      r_count;

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < SLOTS - 1; i++) begin
            if (i_ctl.drop && IW'(i) >= i_pos) begin
                r_level[i] <= r_level[i + 1];
                r_id[i]    <= r_id[i + 1];
                r_op[i]    <= r_op[i + 1];
            end
        end
        for (int i = 0; i < SLOTS; i++) begin
            if (i_ctl.append && r_count == CW'(i)) begin
                r_level[i] <= i_ctl.level;
                r_id[i]    <= i_id;
                r_op[i]    <= i_ctl.op;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctl.append) begin
            r_count <= r_count + 1'b1;
        end else if (i_ctl.drop) begin
            r_count <= r_count - 1'b1;
        end
    end

    assign o_rd_level = r_level[i_rd_idx];
    assign o_rd_id    = r_id[i_rd_idx];
    assign o_rd_op    = r_op[i_rd_idx];
    assign o_count    = r_count;

endmodule

`default_nettype wire

[rtl/spjq_scan_unit.sv]
`timescale 1ns / 1ps
`default_nettype none

// Shared comparator used once per scanned slot. In level mode it tracks the
// most urgent level seen so far; in id mode it checks for an exact id match.
module spjq_scan_unit
    import spjq_pkg::*;
#(
    parameter int ID_BITS = 16
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire t_scan_ctl          i_ctl,
    input  wire logic [LVL_W-1:0]   i_level,
    input  wire logic [ID_BITS-1:0] i_id,
    input  wire logic [ID_W-1:0]    i_key,
    output logic                    o_hit
);

    logic             r_found;
    logic [LVL_W-1:0] r_best_lvl;

    always_comb begin
        if (i_ctl.by_level) begin
            o_hit = !r_found || (i_level < r_best_lvl);
        end else begin
            o_hit = (ID_W'(i_id) == i_key);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
        end else if (i_ctl.clear) begin
            r_found <= 1'b0;
        end else if (i_ctl.step && i_ctl.by_level && o_hit) begin
            r_found <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step && i_ctl.by_level && o_hit) begin
            r_best_lvl <= i_level;
        end
    end

endmodule

`default_nettype wire

[rtl/strict_priority_job_queue_core.sv]
`timescale 1ns / 1ps
`default_nettype none

// Strict-priority job queue with worker wake-up. Each input item is a submit,
// a take or a cancel (tuser), and each produces exactly one result item.
// A submit with priority 1..LEVELS gets the next job id (1 up to the largest
// ID_BITS value, then back to 1), is appended to the slot chain and wakes the
// lowest-numbered idle worker. A take hands out the oldest job of the most
// urgent non-empty level; a cancel removes the oldest job with the given id.
// Timing: a submit, an unused kind, or a take or cancel on an empty queue is
// answered at the edge that accepts it. Otherwise a single comparator scans
// the chain one slot per cycle, a take over all queued jobs and a cancel up
// to its first hit; a hit is then shifted out in a state of its own, and a
// cancel with no hit answers at the end of its scan. The block takes no item
// during a scan or removal, nor while its result register is full and unread.
module strict_priority_job_queue_core
    import spjq_pkg::*;
#(
    parameter int LEVELS  = 8,
    parameter int WORKERS = 4,
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // priority_req[3:0], op_type[5:4], worker[7:6], cancel_id[23:8]
    input  wire logic [23:0] i_s_tdata,
    // kind[1:0]
    input  wire logic [1:0]  i_s_tuser,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // status[2:0], job_id[18:3], job_op[20:19], wake_valid[21],
    // wake_worker[23:22]
    output logic [23:0]      o_m_tdata
);

    localparam int IW = $clog2(SLOTS);
    localparam int CW = $clog2(SLOTS + 1);

    // Input fields.
    logic [3:0]      s_prio;
    logic [1:0]      s_op;
    logic [1:0]      s_worker;
    logic [ID_W-1:0] s_cid;
    t_kind           s_kind;

    assign s_prio   = i_s_tdata[3:0];
    assign s_op     = i_s_tdata[5:4];
    assign s_worker = i_s_tdata[7:6];
    assign s_cid    = i_s_tdata[23:8];
    assign s_kind   = t_kind'(i_s_tuser);

    // Sequencer state and per-item registers.
    t_state             r_state, n_state;
    t_kind              r_kind, n_kind;
    logic [1:0]         r_wk, n_wk;
    logic [ID_W-1:0]    r_cid, n_cid;
    logic [IW-1:0]      r_idx, n_idx;
    logic [IW-1:0]      r_best, n_best;
    logic [ID_BITS-1:0] r_hit_id, n_hit_id;
    logic [1:0]         r_hit_op, n_hit_op;
    logic [ID_BITS-1:0] r_next_id, n_next_id;
    logic [WORKERS-1:0] r_busy, n_busy;
    logic               r_m_valid, n_m_valid;
    t_result            r_m_data, n_m_data;

    // Slot chain and shared comparator connections.
    t_chain_ctl         chain_ctl;
    t_scan_ctl          scan_ctl;
    logic [LVL_W-1:0]   rd_level;
    logic [ID_BITS-1:0] rd_id;
    logic [1:0]         rd_op;
    logic [CW-1:0]      q_count;
    logic               scan_hit;

    logic               out_free;
    logic               s_accept;
    logic               wake_found;
    logic [1:0]         wake_idx;
    logic               wk_ok;
    logic               scan_last;

    assign out_free   = !r_m_valid || i_m_tready;
    assign o_s_tready = (r_state == S_IDLE) && out_free;
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign o_m_tvalid = r_m_valid;
    assign o_m_tdata  = r_m_data;

    // The scan has reached the newest queued job.
    assign scan_last  = ((CW'(r_idx) + 1'b1) == q_count);

    spjq_slot_chain #(
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) u_chain (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctl      (chain_ctl),
        .i_id       (r_next_id),
        .i_pos      (r_best),
        .i_rd_idx   (r_idx),
        .o_rd_level (rd_level),
        .o_rd_id    (rd_id),
        .o_rd_op    (rd_op),
        .o_count    (q_count)
    );

    spjq_scan_unit #(
        .ID_BITS (ID_BITS)
    ) u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (scan_ctl),
        .i_level (rd_level),
        .i_id    (rd_id),
        .i_key   (r_cid),
        .o_hit   (scan_hit)
    );

    // Lowest-numbered idle worker, for the wake-up on submit.
    always_comb begin
        wake_found = 1'b0;
        wake_idx   = '0;
        for (int w = 0; w < WORKERS; w++) begin
            if (!wake_found && !r_busy[w]) begin
                wake_found = 1'b1;
                wake_idx   = 2'(w);
            end
        end
    end

    // Sequencer: next state, result register and command outputs.
    always_comb begin
        n_state   = r_state;
        n_kind    = r_kind;
        n_wk      = r_wk;
        n_cid     = r_cid;
        n_idx     = r_idx;
        n_best    = r_best;
        n_hit_id  = r_hit_id;
        n_hit_op  = r_hit_op;
        n_next_id = r_next_id;
        n_busy    = r_busy;
        n_m_valid = r_m_valid;
        n_m_data  = r_m_data;
        chain_ctl = '0;
        scan_ctl  = '0;
        // The worker index of a take counts only when that worker exists.
        wk_ok     = ({1'b0, r_wk} < 3'(WORKERS));

        scan_ctl.by_level = (r_kind == KIND_TAKE);

        if (r_m_valid && i_m_tready) begin
            n_m_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    n_kind   = s_kind;
                    n_wk     = s_worker;
                    n_cid    = s_cid;
                    n_m_data = '0;
                    unique case (s_kind) inside
                        KIND_SUBMIT: begin
                            n_m_valid = 1'b1;
                            if (s_prio == 4'd0 || s_prio > 4'(LEVELS)) begin
                                n_m_data.status = STS_BAD_PRIO;
                            end else if (q_count >= CW'(SLOTS)) begin
                                n_m_data.status = STS_FULL;
                            end else begin
                                chain_ctl.append = 1'b1;
                                chain_ctl.level  = LVL_W'(s_prio - 4'd1);
                                chain_ctl.op     = s_op;
                                n_m_data.job_id  = ID_W'(r_next_id);
                                if (r_next_id == '1) begin
                                    n_next_id = ID_BITS'(1);
                                end else begin
                                    n_next_id = r_next_id + 1'b1;
                                end
                                if (wake_found) begin
                                    n_m_data.wake_valid  = 1'b1;
                                    n_m_data.wake_worker = wake_idx;
                                    for (int w = 0; w < WORKERS; w++) begin
                                        if (2'(w) == wake_idx) begin
                                            n_busy[w] = 1'b1;
                                        end
                                    end
                                end
                            end
                        end
                        KIND_TAKE, KIND_CANCEL: begin
                            if (q_count == '0) begin
                                n_m_valid = 1'b1;
                                if (s_kind == KIND_TAKE) begin
                                    n_m_data.status = STS_EMPTY;
                                    for (int w = 0; w < WORKERS; w++) begin
                                        if (2'(w) == s_worker) begin
                                            n_busy[w] = 1'b0;
                                        end
                                    end
                                end else begin
                                    n_m_data.status = STS_NOT_FOUND;
                                end
                            end else begin
                                scan_ctl.clear = 1'b1;
                                n_idx          = '0;
                                n_state        = S_SCAN;
                            end
                        end
                        default: begin
                            // Unused kind: an all-zero result and no change.
                            n_m_valid = 1'b1;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                scan_ctl.step = 1'b1;
                if (scan_hit) begin
                    n_best   = r_idx;
                    n_hit_id = rd_id;
                    n_hit_op = rd_op;
                end
                if (r_kind == KIND_CANCEL && scan_hit) begin
                    n_state = S_DROP;
                end else if (scan_last) begin
                    if (r_kind == KIND_TAKE) begin
                        n_state = S_DROP;
                    end else begin
                        n_m_valid       = 1'b1;
                        n_m_data        = '0;
                        n_m_data.status = STS_NOT_FOUND;
                        n_state         = S_IDLE;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DROP: begin
                chain_ctl.drop  = 1'b1;
                n_m_valid       = 1'b1;
                n_m_data        = '0;
                n_m_data.status = STS_OK;
                n_m_data.job_id = ID_W'(r_hit_id);
                if (r_kind == KIND_TAKE) begin
                    n_m_data.job_op = r_hit_op;
                    for (int w = 0; w < WORKERS; w++) begin
                        if (wk_ok && 2'(w) == r_wk) begin
                            n_busy[w] = 1'b1;
                        end
                    end
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_next_id <= ID_BITS'(1);
            r_busy    <= '0;
            r_m_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_next_id <= n_next_id;
            r_busy    <= n_busy;
            r_m_valid <= n_m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind   <= n_kind;
        r_wk     <= n_wk;
        r_cid    <= n_cid;
        r_idx    <= n_idx;
        r_best   <= n_best;
        r_hit_id <= n_hit_id;
        r_hit_op <= n_hit_op;
        r_m_data <= n_m_data;
    end

    // The queue never holds more jobs than it has slots.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_count <= CW'(SLOTS))
        else $error("queued count above slot count");

    // The scan pointer stays inside the valid prefix of the chain.
    a_scan_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> (CW'(r_idx) < q_count))
        else $error("scan index beyond queued jobs");

    // A removal shortens the chain by exactly one job.
    a_drop_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DROP) |=> (q_count == $past(q_count) - 1'b1))
        else $error("removal did not decrement the queued count");

    // No result is pending while a scan is in progress.
    a_scan_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN) |-> !r_m_valid)
        else $error("result register busy during scan");

    // Id zero is never handed out.
    a_id_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_next_id != '0)
        else $error("next job id is zero");

endmodule

`default_nettype wire

[tb/strict_priority_job_queue_checker.sv]
`timescale 1ns / 1ps

// Watches both item channels of the job queue. It keeps its own copy of the
// slot chain, the id counter and the worker flags, and from these it works out
// the result of every accepted input item. It then compares each returned
// result with the oldest expected one.
module strict_priority_job_queue_checker
    import spjq_pkg::*;
#(
    parameter int LEVELS  = 8,
    parameter int WORKERS = 4,
    parameter int SLOTS   = 16,
    parameter int ID_BITS = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    // priority_req[3:0], op_type[5:4], worker[7:6], cancel_id[23:8]
    input  wire logic [23:0] i_s_tdata,
    // kind[1:0]
    input  wire logic [1:0]  i_s_tuser,
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    // status[2:0], job_id[18:3], job_op[20:19], wake_valid[21],
    // wake_worker[23:22]
    input  wire logic [23:0] i_m_tdata,
    output int               o_mismatches,
    output int               o_pending,
    output int               o_checked
);

    localparam int ID_MAX      = (1 << ID_BITS) - 1;
    localparam int MAX_REPORTS = 10;

    // Queued jobs, oldest first; only entries below chain_len are meaningful.
    logic [LVL_W-1:0]   chain_level [SLOTS];
    logic [ID_W-1:0]    chain_id    [SLOTS];
    logic [1:0]         chain_op    [SLOTS];
    int                 chain_len;
    logic [ID_W-1:0]    next_job_id;
    logic [WORKERS-1:0] worker_busy;
    t_result            expected_results [$];

    initial begin
        o_mismatches = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    // Removes one queued job and closes the gap so arrival order is kept.
    function automatic void drop_job(input int pos);
        for (int i = pos; i < SLOTS - 1; i++) begin
            chain_level[i] = chain_level[i + 1];
            chain_id[i]    = chain_id[i + 1];
            chain_op[i]    = chain_op[i + 1];
        end
        chain_len--;
    endfunction

    function automatic t_result predict_job_result(input logic [1:0]      kind,
                                                   input logic [3:0]      prio,
                                                   input logic [1:0]      op,
                                                   input logic [1:0]      wk,
                                                   input logic [ID_W-1:0] cid);
        t_result r;
        int      best;
        int      best_lvl;
        int      hit;
        r = '0;
        case (kind)
            KIND_SUBMIT: begin
                if (prio == 0 || prio > LEVELS) begin
                    r.status = STS_BAD_PRIO;
                end else if (chain_len >= SLOTS) begin
                    r.status = STS_FULL;
                end else begin
                    chain_level[chain_len] = LVL_W'(prio - 1);
                    chain_id[chain_len]    = next_job_id;
                    chain_op[chain_len]    = op;
                    chain_len++;
                    r.status    = STS_OK;
                    r.job_id    = next_job_id;
                    next_job_id = (next_job_id >= ID_MAX) ? ID_W'(1) : next_job_id + 1'b1;
                    // The lowest-numbered idle worker is woken, if any is idle.
                    for (int i = 0; i < WORKERS; i++) begin
                        if (!r.wake_valid && !worker_busy[i]) begin
                            worker_busy[i] = 1'b1;
                            r.wake_valid   = 1'b1;
                            r.wake_worker  = 2'(i);
                        end
                    end
                end
            end
            KIND_TAKE: begin
                // Strict less-than keeps the oldest job among equal levels.
                best     = -1;
                best_lvl = LEVELS;
                for (int i = 0; i < chain_len; i++) begin
                    if (chain_level[i] < best_lvl) begin
                        best_lvl = chain_level[i];
                        best     = i;
                    end
                end
                if (best >= 0) begin
                    r.status = STS_OK;
                    r.job_id = chain_id[best];
                    r.job_op = chain_op[best];
                    drop_job(best);
                    if (wk < WORKERS) worker_busy[wk] = 1'b1;
                end else begin
                    r.status = STS_EMPTY;
                    if (wk < WORKERS) worker_busy[wk] = 1'b0;
                end
            end
            KIND_CANCEL: begin
                // After an id wrap two jobs may share an id; the oldest goes.
                hit = -1;
                for (int i = 0; i < chain_len; i++) begin
                    if (hit < 0 && chain_id[i] == cid) hit = i;
                end
                if (hit >= 0) begin
                    r.status = STS_OK;
                    r.job_id = cid;
                    drop_job(hit);
                end else begin
                    r.status = STS_NOT_FOUND;
                end
            end
            default: begin
                // The unused kind leaves the state alone and answers all zero.
                r = '0;
            end
        endcase
        return r;
    endfunction

    task automatic note_failure(input string msg);
        o_mismatches++;
        if (o_mismatches <= MAX_REPORTS) $display("%t: %s", $realtime, msg);
    endtask

    task automatic check_field(input string field, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            note_failure($sformatf("result %0d: %s expected %0d, got %0d",
                                   o_checked, field, want, got));
        end
    endtask

    always @(posedge i_clk) begin : watch
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            chain_len   = 0;
            next_job_id = ID_W'(1);
            worker_busy = '0;
            expected_results.delete();
            o_checked    = 0;
            o_mismatches = 0;
        end else begin
            // A result leaving at this edge always belongs to an earlier item,
            // so the new expectation can be queued first.
            if (i_s_tvalid && i_s_tready) begin
                expected_results.push_back(predict_job_result(i_s_tuser, i_s_tdata[3:0],
                    i_s_tdata[5:4], i_s_tdata[7:6], i_s_tdata[23:8]));
            end
            if (i_m_tvalid && i_m_tready) begin
                seen = i_m_tdata;
                if (expected_results.size() == 0) begin
                    note_failure($sformatf("result item %h arrived with no job item waiting",
                                           i_m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    check_field("status", want.status, seen.status);
                    check_field("job_id", want.job_id, seen.job_id);
                    check_field("job_op", want.job_op, seen.job_op);
                    check_field("wake_valid", want.wake_valid, seen.wake_valid);
                    check_field("wake_worker", want.wake_worker, seen.wake_worker);
                    o_checked++;
                end
            end
        end
        o_pending = expected_results.size();
    end

endmodule

[tb/tb_strict_priority_job_queue_core.sv]
`timescale 1ns / 1ps

// Drives submit, take and cancel items into the job queue and lets the
// checker judge every result. The run goes through a directed part and then
// random traffic under four idling patterns.
module tb_strict_priority_job_queue_core;
    import spjq_pkg::*;

    localparam int LEVELS  = 8;
    localparam int WORKERS = 4;
    localparam int SLOTS   = 16;
    localparam int ID_BITS = 16;
    localparam int ID_MAX  = (1 << ID_BITS) - 1;

    // The fourth kind code has no meaning in the block and must be ignored.
    localparam logic [1:0] KIND_UNUSED = 2'd3;

    localparam int RESET_CYCLES     = 7;
    localparam int PHASE_ITEMS      = 427;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int DRAIN_LIMIT      = 20000;
    // A take over a full chain scans every slot before the removal; leave ample room.
    localparam int SETTLE_CYCLES    = 4 * (SLOTS + 2);
    localparam int TIMEOUT_NS       = 4_000_000;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    // priority_req[3:0], op_type[5:4], worker[7:6], cancel_id[23:8]
    logic [23:0] s_tdata  = '0;
    // kind[1:0]
    logic [1:0]  s_tuser  = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    // status[2:0], job_id[18:3], job_op[20:19], wake_valid[21],
    // wake_worker[23:22]
    logic [23:0] m_tdata;

    int mismatches;
    int pending;
    int checked;

    int tx_idle_pct  = 0;
    int rx_stall_pct = 0;
    int holds_asked  = 0;
    int holds_served = 0;
    int hold_left    = 0;
    int items_by_kind [4];
    // Rough estimate of the next id, used to aim cancels at queued jobs.
    int id_guess     = 1;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    strict_priority_job_queue_core #(
        .LEVELS  (LEVELS),
        .WORKERS (WORKERS),
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (m_tdata)
    );

    strict_priority_job_queue_checker #(
        .LEVELS  (LEVELS),
        .WORKERS (WORKERS),
        .SLOTS   (SLOTS),
        .ID_BITS (ID_BITS)
    ) checker_inst (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_s_tvalid   (s_tvalid),
        .i_s_tready   (s_tready),
        .i_s_tdata    (s_tdata),
        .i_s_tuser    (s_tuser),
        .i_m_tvalid   (m_tvalid),
        .i_m_tready   (m_tready),
        .i_m_tdata    (m_tdata),
        .o_mismatches (mismatches),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    // Result side. A requested long hold keeps tready low until the hold_left
    // counter runs out; otherwise it stalls at random at the current rate.
    always @(negedge clk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_served != holds_asked) begin
            holds_served <= holds_served + 1;
            hold_left    <= LONG_HOLD_CYCLES - 1;
            m_tready     <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    // Offers one item, starting and ending at a falling edge, and returns once
    // the block has accepted it. tvalid stays high from one item to the next
    // unless an idle gap is drawn.
    task automatic offer_item(input logic [1:0]  kind,
                              input logic [3:0]  prio,
                              input logic [1:0]  op,
                              input logic [1:0]  wk,
                              input logic [15:0] cid);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {cid, wk, op, prio};
        s_tuser  <= kind;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        @(negedge clk);
        items_by_kind[kind]++;
        if (kind == KIND_SUBMIT && prio >= 1 && prio <= LEVELS) begin
            id_guess = (id_guess >= ID_MAX) ? 1 : id_guess + 1;
        end
    endtask

    // In fill mode submits dominate so the chain reaches full; in drain mode
    // takes and cancels dominate so it runs empty again.
    task automatic offer_random_item(input bit filling);
        int unsigned roll;
        logic [1:0]  kind;
        logic [3:0]  prio;
        logic [15:0] cid;
        roll = $urandom_range(0, 99);
        if (roll < 3) kind = KIND_UNUSED;
        else if (roll < (filling ? 68 : 33)) kind = KIND_SUBMIT;
        else if (roll < (filling ? 86 : 82)) kind = KIND_TAKE;
        else kind = KIND_CANCEL;
        if ($urandom_range(0, 99) < 88) prio = 4'($urandom_range(1, LEVELS));
        else if ($urandom_range(0, 1) == 0) prio = 4'd0;
        else prio = 4'($urandom_range(LEVELS + 1, 15));
        // Recent ids mostly hit queued jobs; the rest are arbitrary values.
        if ($urandom_range(0, 99) < 75) cid = 16'(id_guess - $urandom_range(1, 20));
        else cid = 16'($urandom);
        offer_item(kind, prio, 2'($urandom), 2'($urandom), cid);
    endtask

    initial begin
        #(TIMEOUT_NS);
        $display("Run timed out with %0d results still expected.", pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin : stimulus
        int fails;
        int waited;
        int mode_left;
        bit filling;

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed part: empty take, unknown cancel, bad priorities at both
        // ends, the unused kind, a full chain with all workers busy, cancels
        // of the newest and the oldest job, then takes until empty again.
        offer_item(KIND_TAKE, 4'd0, 2'd0, 2'd2, 16'h0000);
        offer_item(KIND_CANCEL, 4'd0, 2'd0, 2'd0, 16'h0000);
        offer_item(KIND_SUBMIT, 4'd0, 2'd1, 2'd0, 16'h0000);
        offer_item(KIND_SUBMIT, 4'd15, 2'd2, 2'd0, 16'h0000);
        offer_item(KIND_SUBMIT, 4'(LEVELS + 1), 2'd3, 2'd0, 16'h0000);
        offer_item(KIND_UNUSED, 4'd15, 2'd3, 2'd3, 16'hffff);
        for (int n = 0; n < SLOTS; n++) begin
            offer_item(KIND_SUBMIT, 4'(LEVELS - n % LEVELS), 2'(n), 2'(n), 16'(~n));
        end
        offer_item(KIND_SUBMIT, 4'd1, 2'd0, 2'd0, 16'h0000);
        offer_item(KIND_CANCEL, 4'd0, 2'd0, 2'd0, 16'hffff);
        offer_item(KIND_CANCEL, 4'd0, 2'd0, 2'd0, 16'(SLOTS));
        offer_item(KIND_CANCEL, 4'd0, 2'd0, 2'd0, 16'd1);
        for (int n = 0; n < SLOTS - 1; n++) begin
            offer_item(KIND_TAKE, 4'd0, 2'd0, 2'(n), 16'h0000);
        end
        // The directed part hands out ids 1 to SLOTS.
        id_guess = SLOTS + 1;

        // Random traffic under four idling patterns. Midway through the first
        // one the result side holds off long enough to back up the input.
        filling   = 1'b1;
        mode_left = 0;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 49;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 49;
                end
                default: begin
                    tx_idle_pct  = 10;
                    rx_stall_pct = 10;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (mode_left == 0) begin
                    filling   = !filling;
                    mode_left = $urandom_range(8, 40);
                end
                mode_left--;
                if (phase == 0 && n == PHASE_ITEMS / 2) holds_asked++;
                offer_random_item(filling);
            end
        end

        s_tvalid     <= 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        waited       = 0;
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(negedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(negedge clk);

        fails = mismatches;
        if (pending != 0) begin
            $display("%0d expected results never arrived.", pending);
            fails++;
        end
        $display("Sent %0d submits, %0d takes, %0d cancels and %0d unused-kind items;",
                 items_by_kind[KIND_SUBMIT], items_by_kind[KIND_TAKE],
                 items_by_kind[KIND_CANCEL], items_by_kind[KIND_UNUSED]);
        $display("checked %0d results over directed cases and four idling patterns.",
                 checked);
        if (fails == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/spjq_pkg.sv
rtl/spjq_slot_chain.sv
rtl/spjq_scan_unit.sv
rtl/strict_priority_job_queue_core.sv
tb/strict_priority_job_queue_checker.sv
tb/tb_strict_priority_job_queue_core.sv
